// ===== hdl/drive_command_supervisor_core_assert.svh =====
// assertion helpers shared by the supervisor rtl
// both expect clk and rst_n in scope
`ifndef DRIVE_COMMAND_SUPERVISOR_CORE_ASSERT_SVH
`define DRIVE_COMMAND_SUPERVISOR_CORE_ASSERT_SVH

// same-cycle implication
`define DCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dcs_pkg.sv =====
package dcs_pkg;

  // request types
  localparam logic [2:0] REQ_DISTANCE = 3'd0;
  localparam logic [2:0] REQ_STOP     = 3'd1;
  localparam logic [2:0] REQ_SPEED    = 3'd2;
  localparam logic [2:0] REQ_STEER    = 3'd3;
  localparam logic [2:0] REQ_LOST     = 3'd4;
  localparam logic [2:0] REQ_TICK     = 3'd5;

  // register indexes (byte address 4*index)
  localparam logic [2:0] REG_START_SPEED      = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED        = 3'd1;
  localparam logic [2:0] REG_MAX_STEER        = 3'd2;
  localparam logic [2:0] REG_MIN_STEER        = 3'd3;
  localparam logic [2:0] REG_SAFETY_DISTANCE  = 3'd4;
  localparam logic [2:0] REG_STANDSTILL_TICKS = 3'd5;
  localparam logic [2:0] REG_STEER_DEADBAND   = 3'd6;

  localparam int PADDR_W = 5;

  // reset values
  localparam logic [12:0]        START_SPEED_RST      = 13'd450;
  localparam logic [12:0]        MAX_SPEED_RST        = 13'd1024;
  localparam logic signed [13:0] MAX_STEER_RST        = 14'sd1638;
  localparam logic signed [13:0] MIN_STEER_RST        = -14'sd1638;
  localparam logic [15:0]        SAFETY_DISTANCE_RST  = 16'd614;
  localparam logic [15:0]        STANDSTILL_TICKS_RST = 16'd7000;
  localparam logic [12:0]        STEER_DEADBAND_RST   = 13'd205;
  localparam logic [12:0]        LAST_SPEED_RST       = 13'd410;

  typedef struct packed {
    logic [12:0]        start_speed;
    logic [12:0]        max_speed;
    logic signed [13:0] max_steer;
    logic signed [13:0] min_steer;
    logic [15:0]        safety_distance;
    logic [15:0]        standstill_ticks;
    logic [12:0]        steer_deadband;
  } cfg_t;

endpackage

// ===== hdl/dcs_cfg.sv =====
module dcs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dcs_pkg::cfg_t               cfg
);
  import dcs_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_speed      <= START_SPEED_RST;
      cfg_r.max_speed        <= MAX_SPEED_RST;
      cfg_r.max_steer        <= MAX_STEER_RST;
      cfg_r.min_steer        <= MIN_STEER_RST;
      cfg_r.safety_distance  <= SAFETY_DISTANCE_RST;
      cfg_r.standstill_ticks <= STANDSTILL_TICKS_RST;
      cfg_r.steer_deadband   <= STEER_DEADBAND_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_SPEED:      cfg_r.start_speed      <= pwdata[12:0];
        REG_MAX_SPEED:        cfg_r.max_speed        <= pwdata[12:0];
        REG_MAX_STEER:        cfg_r.max_steer        <= $signed(pwdata[13:0]);
        REG_MIN_STEER:        cfg_r.min_steer        <= $signed(pwdata[13:0]);
        REG_SAFETY_DISTANCE:  cfg_r.safety_distance  <= pwdata[15:0];
        REG_STANDSTILL_TICKS: cfg_r.standstill_ticks <= pwdata[15:0];
        REG_STEER_DEADBAND:   cfg_r.steer_deadband   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_SPEED:      prdata = {19'd0, cfg_r.start_speed};
      REG_MAX_SPEED:        prdata = {19'd0, cfg_r.max_speed};
      REG_MAX_STEER:        prdata = {{18{cfg_r.max_steer[13]}}, cfg_r.max_steer};
      REG_MIN_STEER:        prdata = {{18{cfg_r.min_steer[13]}}, cfg_r.min_steer};
      REG_SAFETY_DISTANCE:  prdata = {16'd0, cfg_r.safety_distance};
      REG_STANDSTILL_TICKS: prdata = {16'd0, cfg_r.standstill_ticks};
      REG_STEER_DEADBAND:   prdata = {19'd0, cfg_r.steer_deadband};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/drive_command_supervisor_core.sv =====
// Drive command supervisor: one event in, one result out.
// Input channel (in_*): an event is taken at a rising edge with in_valid high
// and in_stall low. in_req_type picks distance, stop sign, speed correction,
// steering correction, out of sight or tick; the other fields are read as
// that type needs them.
// Result channel (out_*): every event gives exactly one result with optional
// pedal and steering commands plus the latched standstill flag.
// The event is registered, then evaluated against the kept speed/steering
// state into the output register. Throughput is one event per cycle while
// out_stall holds no result; the state update per advance is what sets it.
// When out_stall holds a result, the input register keeps its event and
// in_stall rises; a new event is taken as soon as the output register frees.
// Synchronous reset (rst_n low) empties both stages, sets speed and steering
// to zero, last speed to 0.1, clears the tick count and the standstill flag,
// and restores the register defaults. The user must write the registers
// (cfg_* APB, 4-byte stride) only while idle; the block does not enforce it.
`include "drive_command_supervisor_core_assert.svh"

module drive_command_supervisor_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_req_type,
  input  logic [15:0]                 in_sensor_id,
  input  logic [15:0]                 in_distance,
  input  logic                        in_stop_sign_present,
  input  logic signed [13:0]          in_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_pedal_valid,
  output logic [12:0]                 out_pedal_position,
  output logic                        out_steer_valid,
  output logic signed [13:0]          out_steering_angle,
  output logic                        out_standstill,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dcs_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import dcs_pkg::*;

  cfg_t cfg;

  dcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input stage
  logic               s1_valid_r;
  logic [2:0]         s1_req_type_r;
  logic [15:0]        s1_sensor_id_r;
  logic [15:0]        s1_distance_r;
  logic               s1_stop_r;
  logic signed [13:0] s1_amount_r;

  // kept state
  logic [12:0]        car_speed_r, car_speed_nxt;
  logic signed [13:0] car_steer_r, car_steer_nxt;
  logic [12:0]        last_speed_r, last_speed_nxt;
  logic [15:0]        zero_ticks_r, zero_ticks_nxt;
  logic               flag_r, flag_nxt;

  // output stage
  logic               out_valid_r;
  logic               pedal_valid_r, pedal_valid_nxt;
  logic [12:0]        pedal_pos_r, pedal_pos_nxt;
  logic               steer_valid_r, steer_valid_nxt;
  logic signed [13:0] steer_angle_r, steer_angle_nxt;
  logic               standstill_r;

  logic out_free, advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_type_r  <= in_req_type;
      s1_sensor_id_r <= in_sensor_id;
      s1_distance_r  <= in_distance;
      s1_stop_r      <= in_stop_sign_present;
      s1_amount_r    <= in_amount;
    end
  end

  // speed correction
  logic signed [15:0] st16, max16, amt16, spd_sum, spd_clamp;
  logic [12:0]        spd_base, spd_new;

  always_comb begin
    st16  = $signed({3'd0, cfg.start_speed});
    max16 = $signed({3'd0, cfg.max_speed});
    amt16 = 16'(s1_amount_r);
    spd_base = (car_speed_r < cfg.start_speed && s1_amount_r > 14'sd0) ?
               cfg.start_speed : car_speed_r;
    spd_sum   = $signed({3'd0, spd_base}) + amt16;
    spd_clamp = (spd_sum > max16) ? max16 : spd_sum;
    if (spd_base < cfg.start_speed && s1_amount_r < 14'sd0) begin
      spd_new = 13'd0;
    end else if (spd_clamp < st16) begin
      spd_new = 13'd0;
    end else begin
      spd_new = spd_clamp[12:0];
    end
  end

  // steering correction
  logic signed [14:0] db15, amt15, steer15, spd15, slow_lim;
  logic signed [13:0] steer_hi, steer_new;
  logic               near_straight, far_off, slow;

  always_comb begin
    db15     = $signed({2'd0, cfg.steer_deadband});
    amt15    = 15'(s1_amount_r);
    steer15  = 15'(car_steer_r);
    spd15    = $signed({2'd0, car_speed_r});
    slow_lim = $signed({2'd0, cfg.start_speed}) - db15;
    near_straight = (amt15 >= -db15) && (amt15 < db15);
    far_off       = (steer15 <= -db15) || (steer15 > db15);
    slow          = spd15 < slow_lim;
    steer_hi = (s1_amount_r > cfg.max_steer) ? cfg.max_steer : s1_amount_r;
    if (near_straight && far_off && slow) begin
      steer_new = 14'sd0;
    end else begin
      steer_new = (steer_hi < cfg.min_steer) ? cfg.min_steer : steer_hi;
    end
  end

  // event evaluation
  logic        mf_en;
  logic [12:0] mf_speed;

  always_comb begin
    car_speed_nxt   = car_speed_r;
    car_steer_nxt   = car_steer_r;
    last_speed_nxt  = last_speed_r;
    zero_ticks_nxt  = zero_ticks_r;
    flag_nxt        = flag_r;
    pedal_valid_nxt = 1'b0;
    pedal_pos_nxt   = 13'd0;
    steer_valid_nxt = 1'b0;
    steer_angle_nxt = 14'sd0;
    mf_en           = 1'b0;
    mf_speed        = 13'd0;

    case (s1_req_type_r)
      REQ_DISTANCE: begin
        if (s1_sensor_id_r == 16'd0 && s1_distance_r <= cfg.safety_distance) begin
          mf_en           = 1'b1;
          car_speed_nxt   = 13'd0;
          car_steer_nxt   = 14'sd0;
          steer_valid_nxt = 1'b1;
        end
      end
      REQ_STOP: begin
        if (!s1_stop_r) begin
          pedal_valid_nxt = 1'b1;
        end
      end
      REQ_SPEED: begin
        if (!flag_r) begin
          car_speed_nxt = spd_new;
          mf_en         = 1'b1;
          mf_speed      = spd_new;
        end
      end
      REQ_STEER: begin
        if (!flag_r) begin
          car_steer_nxt   = steer_new;
          steer_valid_nxt = 1'b1;
          steer_angle_nxt = steer_new;
        end
      end
      REQ_LOST: begin
        if (flag_r) begin
          steer_valid_nxt = 1'b1;
          mf_en           = 1'b1;
          mf_speed        = cfg.start_speed;
        end
      end
      REQ_TICK: begin
        if (!flag_r && last_speed_r == 13'd0 && zero_ticks_r != 16'hFFFF) begin
          zero_ticks_nxt = zero_ticks_r + 16'd1;
        end
      end
      default: ;
    endcase

    // pedal command and standstill bookkeeping
    if (mf_en) begin
      pedal_valid_nxt = 1'b1;
      pedal_pos_nxt   = mf_speed;
      if (!flag_r) begin
        if (last_speed_r != 13'd0 && mf_speed == 13'd0) begin
          zero_ticks_nxt = 16'd0;
        end else if (last_speed_r == 13'd0 && mf_speed == 13'd0 &&
                     zero_ticks_r >= cfg.standstill_ticks) begin
          flag_nxt = 1'b1;
        end
        last_speed_nxt = mf_speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_speed_r  <= 13'd0;
      car_steer_r  <= 14'sd0;
      last_speed_r <= LAST_SPEED_RST;
      zero_ticks_r <= 16'd0;
      flag_r       <= 1'b0;
    end else if (advance) begin
      car_speed_r  <= car_speed_nxt;
      car_steer_r  <= car_steer_nxt;
      last_speed_r <= last_speed_nxt;
      zero_ticks_r <= zero_ticks_nxt;
      flag_r       <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pedal_valid_r <= pedal_valid_nxt;
      pedal_pos_r   <= pedal_pos_nxt;
      steer_valid_r <= steer_valid_nxt;
      steer_angle_r <= steer_angle_nxt;
      standstill_r  <= flag_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pedal_valid    = pedal_valid_r;
  assign out_pedal_position = pedal_pos_r;
  assign out_steer_valid    = steer_valid_r;
  assign out_steering_angle = steer_angle_r;
  assign out_standstill     = standstill_r;

  `DCS_ASSERT_NEXT(a_flag_sticky, flag_r, flag_r, "standstill flag cleared without reset")
  `DCS_ASSERT_NEXT(a_ticks_frozen, flag_r, $stable(zero_ticks_r), "tick count moved while latched")
  `DCS_ASSERT_IMPL(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r, "stall with empty stage")
  `DCS_ASSERT_IMPL(a_dual_cmd_straight, out_valid_r && pedal_valid_r && steer_valid_r,
                   steer_angle_r == 14'sd0, "combined command with nonzero steering")

endmodule
